@@ design/u8dec_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared widths, lead-byte masks and the lead classifier for the
// six-byte UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 31;
    localparam int unsigned REM_W  = 3;
    localparam int unsigned CONT_W = 6;

    // Lead-byte class boundaries
    localparam logic [BYTE_W-1:0] LEAD_CONT  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD_TWO   = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD_THREE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_FOUR  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD_FIVE  = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD_SIX   = 8'hFC;

    // Payload masks
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;
    localparam logic [BYTE_W-1:0] MASK_TWO   = 8'h1F;
    localparam logic [BYTE_W-1:0] MASK_THREE = 8'h0F;
    localparam logic [BYTE_W-1:0] MASK_FOUR  = 8'h07;
    localparam logic [BYTE_W-1:0] MASK_FIVE  = 8'h03;
    localparam logic [BYTE_W-1:0] MASK_SIX   = 8'h01;

    // Follow-on byte counts per lead class
    localparam logic [REM_W-1:0] REM_IDLE  = 3'd0;
    localparam logic [REM_W-1:0] REM_LAST  = 3'd1;
    localparam logic [REM_W-1:0] REM_TWO   = 3'd1;
    localparam logic [REM_W-1:0] REM_THREE = 3'd2;
    localparam logic [REM_W-1:0] REM_FOUR  = 3'd3;
    localparam logic [REM_W-1:0] REM_FIVE  = 3'd4;
    localparam logic [REM_W-1:0] REM_SIX   = 3'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] payload;
        logic [REM_W-1:0]  remaining;
    } lead_info_t;

    // Classify a multi-byte lead (caller guarantees byte >= 0xC0)
    function automatic lead_info_t classify_lead(input logic [BYTE_W-1:0] b);
        lead_info_t info;
        if (b < LEAD_THREE) begin
            info.payload   = b & MASK_TWO;
            info.remaining = REM_TWO;
        end else if (b < LEAD_FOUR) begin
            info.payload   = b & MASK_THREE;
            info.remaining = REM_THREE;
        end else if (b < LEAD_FIVE) begin
            info.payload   = b & MASK_FOUR;
            info.remaining = REM_FOUR;
        end else if (b < LEAD_SIX) begin
            info.payload   = b & MASK_FIVE;
            info.remaining = REM_FIVE;
        end else begin
            info.payload   = b & MASK_SIX;
            info.remaining = REM_SIX;
        end
        return info;
    endfunction

endpackage
`default_nettype wire

@@ design/utf8_stream_decoder_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Byte-serial decoder for the original six-byte UTF-8 form.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready/s_data_byte) carries one raw text byte per
//   transfer. Result channel (m_valid/m_ready/m_code_point/m_bad_lead) carries
//   one decoded character, or a bad-lead flag with code point zero.
//   An ASCII byte or a bad lead (0x80..0xBF while idle) gives a result on the
//   cycle after its transfer. A multi-byte character gives no result for its
//   lead and middle bytes; its result appears in the cycle after the transfer
//   of its last byte. Continuation bytes are not checked; only their low six
//   bits are used.
//   Throughput is one byte per cycle unless a pending result stalls: the
//   sequence state and the output register are updated by a single level of
//   shift/mask logic. The output register doubles as the decoupling stage:
//   s_ready stays high while the result register is empty or being drained,
//   so a new byte can be taken in the same cycle a result leaves. If the
//   receiver stalls with a result pending, s_ready drops and the result holds until taken.
//   Reset (aresetn low, synchronous) empties the result register and returns
//   the decoder to idle, awaiting a lead byte.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [u8dec_pkg::BYTE_W-1:0]  s_data_byte,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [u8dec_pkg::CP_W-1:0]         m_code_point,
    output logic                               m_bad_lead
);

    logic [u8dec_pkg::REM_W-1:0] remaining_reg, remaining_next;
    logic [u8dec_pkg::CP_W-1:0]  acc_reg, acc_next;
    logic                        m_valid_reg, m_valid_next;
    logic [u8dec_pkg::CP_W-1:0]  code_point_reg, code_point_next;
    logic                        bad_lead_reg, bad_lead_next;

    logic                        in_xfer;
    logic [u8dec_pkg::CP_W-1:0]  acc_shifted;
    u8dec_pkg::lead_info_t       lead;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;

    // Shift in one continuation payload, drop bits above the code point width
    assign acc_shifted = {acc_reg[u8dec_pkg::CP_W-u8dec_pkg::CONT_W-1:0],
                          s_data_byte[u8dec_pkg::CONT_W-1:0]};
    assign lead = u8dec_pkg::classify_lead(s_data_byte);

    // Decode step for one byte
    always_comb begin
        remaining_next  = remaining_reg;
        acc_next        = acc_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        code_point_next = code_point_reg;
        bad_lead_next   = bad_lead_reg;
        if (in_xfer) begin
            if (remaining_reg != u8dec_pkg::REM_IDLE) begin
                remaining_next = remaining_reg - 1'b1;
                if (remaining_reg == u8dec_pkg::REM_LAST) begin
                    m_valid_next    = 1'b1;
                    code_point_next = acc_shifted;
                    bad_lead_next   = 1'b0;
                    acc_next        = '0;
                end else begin
                    acc_next = acc_shifted;
                end
            end else if (s_data_byte < u8dec_pkg::LEAD_CONT) begin
                m_valid_next    = 1'b1;
                code_point_next = u8dec_pkg::CP_W'(s_data_byte);
                bad_lead_next   = 1'b0;
            end else if (s_data_byte < u8dec_pkg::LEAD_TWO) begin
                m_valid_next    = 1'b1;
                code_point_next = '0;
                bad_lead_next   = 1'b1;
            end else begin
                remaining_next = lead.remaining;
                acc_next       = u8dec_pkg::CP_W'(lead.payload);
            end
        end
    end

    // Sequence state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remaining_reg <= u8dec_pkg::REM_IDLE;
            acc_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            remaining_reg <= remaining_next;
            acc_reg       <= acc_next;
            m_valid_reg   <= m_valid_next;
        end
        code_point_reg <= code_point_next;
        bad_lead_reg   <= bad_lead_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_code_point = code_point_reg;
    assign m_bad_lead   = bad_lead_reg;

endmodule
`default_nettype wire

@@ design/u8dec_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u8dec_checker
// Port-level checks for the UTF-8 stream decoder, bound to the decoder unit.
// ----------------------------------------------------------------------------
module u8dec_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic [u8dec_pkg::BYTE_W-1:0]  s_data_byte,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [u8dec_pkg::CP_W-1:0]    m_code_point,
    input wire logic                          m_bad_lead
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // Error results carry a zero code point
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bad_lead) |-> (m_code_point == '0))
        else $error("bad lead with nonzero code point");

    // Input is never blocked while the result register is empty
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // A new result needs an input transfer on the previous cycle
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid && !m_ready)) |-> $past(s_valid && s_ready))
        else $error("result without an input transfer");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_code_point) && $stable(m_bad_lead)))
        else $error("stalled result changed");

endmodule

bind utf8_stream_decoder_unit u8dec_checker u_u8dec_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_data_byte  (s_data_byte),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_code_point (m_code_point),
    .m_bad_lead   (m_bad_lead)
);
`default_nettype wire
